// File: hdl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg - shared types and constants of the 3x3 box blur stream
//
// Register codes, stream opcodes, the column word passed from the front
// end to the back end, and the reciprocal table used for the rounded mean.
// ----------------------------------------------------------------------------
package bbs_pkg;

	// Default sizing of the line stores and the row counter
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Configuration registers
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	// Pixel packed as R in [23:16], G in [15:8], B in [7:0]
	localparam int CH_W   = 8;
	localparam int NUM_CH = 3;
	typedef logic [NUM_CH*CH_W-1:0] pixel_t;

	// Column queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QLVL_W = 3;

	// Window position flags of the result a column completes
	typedef struct packed {
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} win_flags_t;

	// One new window column: upper row, middle row, current row
	typedef struct packed {
		pixel_t     top;
		pixel_t     mid;
		pixel_t     bot;
		win_flags_t flags;
	} col_item_t;

	// Mean arithmetic: (2*sum + cnt) / (2*cnt) as a multiply by a reciprocal
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int NUM_W       = 13;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// ceil(2^20 / (2*cnt)); exact quotient for every numerator below 2^13
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] m;
		case (cnt)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd6:    m = 20'd87382;
			4'd9:    m = 20'd58255;
			default: m = 20'd524288;
		endcase
		return m;
	endfunction

endpackage

// File: hdl/bbs_if.sv
// ----------------------------------------------------------------------------
// bbs_if - stream channels of the box blur
//
// Valid/ready channels for incoming pixels and outgoing blurred pixels.
// A word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bbs_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output opcode, output red_in, output green_in,
		output blue_in, input ready);
	modport sink (input valid, input opcode, input red_in, input green_in,
		input blue_in, output ready);
endinterface

interface bbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_done;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output frame_done, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input frame_done, output ready);
endinterface

// File: hdl/bbs_front.sv
// ----------------------------------------------------------------------------
// bbs_front - input side of the box blur
//
// Accepts words, drops those that do nothing, tracks the frame position,
// runs the two line stores and pushes one window column per useful word.
// ----------------------------------------------------------------------------
module bbs_front #(
	parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bbs_pkg::WIDTH_REG_W-1:0]   cfg_width,
	input  logic [bbs_pkg::HEIGHT_REG_W-1:0]  cfg_height,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  bbs_pkg::pixel_t                   in_pixel,
	input  logic [bbs_pkg::QLVL_W-1:0]        q_level,
	output logic                              push,
	output bbs_pkg::col_item_t                push_item
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int DW = $clog2(MAX_WIDTH + 2);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [CW-1:0] w;
	logic [RW-1:0] h;
	logic [DW-1:0] w_ext;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [DW-1:0] dc_q;
	logic [CW-1:0] oc_q;
	logic [RW-1:0] or_q;

	logic                acc;
	logic                is_drain;
	logic                in_frame;
	logic                take_pix;
	logic                take_drn;
	logic                take;
	logic                emit;
	logic                frame_end;
	logic [DW-1:0]       dc_wrap;
	logic [AW-1:0]       rd_addr;
	bbs_pkg::win_flags_t flags;

	logic                valid_s1;
	logic [AW-1:0]       addr_s1;
	bbs_pkg::pixel_t     pix_s1;
	bbs_pkg::win_flags_t flags_s1;

	bbs_pkg::pixel_t mem_a [MAX_WIDTH];
	bbs_pkg::pixel_t mem_b [MAX_WIDTH];
	bbs_pkg::pixel_t rd_a_q;
	bbs_pkg::pixel_t rd_b_q;
	logic            fwd_q;
	bbs_pkg::pixel_t fwd_a_q;
	bbs_pkg::pixel_t fwd_b_q;
	bbs_pkg::pixel_t a_eff;
	bbs_pkg::pixel_t b_eff;

	// Clamp the size registers into the supported range
	always_comb begin
		if (cfg_width == '0) begin
			w = CW'(1);
		end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
			w = CW'(MAX_WIDTH);
		end else begin
			w = CW'(cfg_width);
		end
		if (cfg_height == '0) begin
			h = RW'(1);
		end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
			h = RW'(MAX_HEIGHT);
		end else begin
			h = RW'(cfg_height);
		end
		w_ext = DW'(w);
	end

	// Hold off input while the queue could not take what is in flight
	assign in_ready = (q_level + bbs_pkg::QLVL_W'(valid_s1)) < bbs_pkg::QLVL_W'(bbs_pkg::QDEPTH);

	// Classify the word
	always_comb begin
		acc       = in_valid && in_ready;
		is_drain  = (opcode == bbs_pkg::OP_DRAIN);
		in_frame  = row_q < h;
		take_pix  = !is_drain && in_frame;
		take_drn  = is_drain && !in_frame && (dc_q <= w_ext);
		take      = acc && (take_pix || take_drn);
		frame_end = take_drn && (dc_q >= w_ext);
		dc_wrap   = (dc_q >= w_ext) ? (dc_q - w_ext) : dc_q;
		rd_addr   = is_drain ? dc_wrap[AW-1:0] : col_q[AW-1:0];
		if (is_drain) begin
			emit = (h != RW'(1)) || (dc_q != '0);
		end else begin
			emit = (row_q > RW'(1)) || ((row_q == RW'(1)) && (col_q != '0));
		end
		flags.emit     = emit;
		flags.top_ok   = (or_q != '0);
		flags.bot_ok   = ((RW+1)'(or_q) + (RW+1)'(1)) < (RW+1)'(h);
		flags.left_ok  = (oc_q != '0);
		flags.right_ok = ((CW+1)'(oc_q) + (CW+1)'(1)) < (CW+1)'(w);
		flags.last     = (((RW+1)'(or_q) + (RW+1)'(1)) == (RW+1)'(h)) &&
			(((CW+1)'(oc_q) + (CW+1)'(1)) == (CW+1)'(w));
	end

	// Advance frame position, drain count and result position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			dc_q     <= '0;
			oc_q     <= '0;
			or_q     <= '0;
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take) begin
				fwd_q <= valid_s1 && (addr_s1 == rd_addr);
			end
			if (take && emit) begin
				if (flags.right_ok) begin
					oc_q <= oc_q + CW'(1);
				end else begin
					oc_q <= '0;
					or_q <= or_q + RW'(1);
				end
			end
			if (take_pix && acc) begin
				if (((CW+1)'(col_q) + (CW+1)'(1)) >= (CW+1)'(w)) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (take_drn && acc) begin
				dc_q <= dc_q + DW'(1);
			end
			if (acc && frame_end) begin
				col_q <= '0;
				row_q <= '0;
				dc_q  <= '0;
				oc_q  <= '0;
				or_q  <= '0;
			end
		end
	end

	// Line stores: read on accept, write back in the following cycle
	always_ff @(posedge clk) begin
		if (take) begin
			rd_a_q <= mem_a[rd_addr];
			rd_b_q <= mem_b[rd_addr];
		end
		if (valid_s1) begin
			mem_a[addr_s1] <= pix_s1;
			mem_b[addr_s1] <= a_eff;
		end
	end

	// Stage payload and bypass data for a read of the entry being written
	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1  <= rd_addr;
			pix_s1   <= is_drain ? '0 : in_pixel;
			flags_s1 <= flags;
			fwd_a_q  <= pix_s1;
			fwd_b_q  <= a_eff;
		end
	end

	assign a_eff = fwd_q ? fwd_a_q : rd_a_q;
	assign b_eff = fwd_q ? fwd_b_q : rd_b_q;

	// Push the new column
	assign push            = valid_s1;
	assign push_item.top   = b_eff;
	assign push_item.mid   = a_eff;
	assign push_item.bot   = pix_s1;
	assign push_item.flags = flags_s1;

endmodule

// File: hdl/bbs_queue.sv
// ----------------------------------------------------------------------------
// bbs_queue - column queue between front and back
//
// Four-entry first-in first-out buffer of window columns.
// ----------------------------------------------------------------------------
module bbs_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bbs_pkg::col_item_t         push_item,
	input  logic                       pop,
	output logic                       head_valid,
	output bbs_pkg::col_item_t         head_item,
	output logic [bbs_pkg::QLVL_W-1:0] level
);

	bbs_pkg::col_item_t               entry_q [bbs_pkg::QDEPTH];
	logic [bbs_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [bbs_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [bbs_pkg::QLVL_W-1:0]       level_q;

	// Store incoming columns
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bbs_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bbs_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + bbs_pkg::QLVL_W'(1);
				2'b01:   level_q <= level_q - bbs_pkg::QLVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	assign head_valid = (level_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign level      = level_q;

	// Front must never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q != bbs_pkg::QLVL_W'(bbs_pkg::QDEPTH)))
		else $error("column queue overflow");

	// Back must never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (level_q != '0))
		else $error("column queue underflow");

endmodule

// File: hdl/bbs_back.sv
// ----------------------------------------------------------------------------
// bbs_back - window and mean pipeline of the box blur
//
// Shifts queued columns into the 3x3 window, sums the neighbors inside the
// image, divides by the count with rounding, and holds the result word.
// ----------------------------------------------------------------------------
module bbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  bbs_pkg::col_item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic               frame_done
);

	localparam int CW  = bbs_pkg::CH_W;
	localparam int NCH = bbs_pkg::NUM_CH;

	logic adv;

	bbs_pkg::pixel_t     win_q [3][3];
	logic                v_s1;
	bbs_pkg::win_flags_t flags_s1;

	logic [CW+1:0]                 colsum [NCH][3];
	logic [bbs_pkg::SUM_W-1:0]     sum_c  [NCH];
	logic [1:0]                    rows;
	logic [1:0]                    cols;
	logic [bbs_pkg::CNT_W-1:0]     cnt;

	logic                          v_s2;
	logic                          last_s2;
	logic [bbs_pkg::SUM_W-1:0]     sum_s2 [NCH];
	logic [bbs_pkg::CNT_W-1:0]     cnt_s2;
	logic [bbs_pkg::RECIP_W-1:0]   m_s2;

	logic                          v_s3;
	logic                          last_s3;
	logic [bbs_pkg::PROD_W-1:0]    prod_s3 [NCH];
	logic [bbs_pkg::NUM_W-1:0]     quot    [NCH];

	logic                          out_valid_q;
	logic [CW-1:0]                 res_q   [NCH];
	logic                          last_q;

	// Whole pipeline moves when the output word is free or being taken
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && q_valid;

	// Shift the window on every popped column
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= q_item.top;
			win_q[1][2] <= q_item.mid;
			win_q[2][2] <= q_item.bot;
		end
	end

	// Masked column sums, then row of columns, plus neighbor count
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			for (int j = 0; j < 3; j++) begin
				colsum[c][j] = (CW+2)'(win_q[1][j][(NCH-1-c)*CW +: CW]);
				if (flags_s1.top_ok) begin
					colsum[c][j] = colsum[c][j] + (CW+2)'(win_q[0][j][(NCH-1-c)*CW +: CW]);
				end
				if (flags_s1.bot_ok) begin
					colsum[c][j] = colsum[c][j] + (CW+2)'(win_q[2][j][(NCH-1-c)*CW +: CW]);
				end
			end
			sum_c[c] = bbs_pkg::SUM_W'(colsum[c][1]);
			if (flags_s1.left_ok) begin
				sum_c[c] = sum_c[c] + bbs_pkg::SUM_W'(colsum[c][0]);
			end
			if (flags_s1.right_ok) begin
				sum_c[c] = sum_c[c] + bbs_pkg::SUM_W'(colsum[c][2]);
			end
		end
		rows = 2'd1 + 2'(flags_s1.top_ok) + 2'(flags_s1.bot_ok);
		cols = 2'd1 + 2'(flags_s1.left_ok) + 2'(flags_s1.right_ok);
		cnt  = bbs_pkg::CNT_W'(rows) * bbs_pkg::CNT_W'(cols);
	end

	// Extract the quotient; it is clipped to one channel when registered
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			quot[c] = prod_s3[c][bbs_pkg::PROD_W-1 -: bbs_pkg::NUM_W];
		end
	end

	// Valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_pop && q_item.flags.emit;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Payload of the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= q_item.flags;
			last_s2  <= flags_s1.last;
			cnt_s2   <= cnt;
			m_s2     <= bbs_pkg::recip(cnt);
			last_s3  <= last_s2;
			last_q   <= last_s3;
			for (int c = 0; c < NCH; c++) begin
				sum_s2[c]  <= sum_c[c];
				prod_s3[c] <= bbs_pkg::PROD_W'({sum_s2[c], 1'b0} + bbs_pkg::NUM_W'(cnt_s2)) *
					bbs_pkg::PROD_W'(m_s2);
				res_q[c]   <= (quot[c] > bbs_pkg::NUM_W'(255)) ? {CW{1'b1}} : quot[c][CW-1:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = res_q[0];
	assign green_out  = res_q[1];
	assign blue_out   = res_q[2];
	assign frame_done = last_q;

	// A finished quotient always lands in the output word
	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv) |=> out_valid_q)
		else $error("result lost between divide stage and output");

endmodule

// File: hdl/box_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream - 3x3 box blur over an RGB raster stream
//
// in_ch carries pixels (opcode pixel) in raster order and, after the last
// pixel of a frame, width+1 drain words (opcode drain) that flush the final
// results. out_ch carries one blurred pixel per result with frame_done set
// on the frame's last one. Each channel is the rounded-half-up mean of the
// neighbors that lie inside the image (1 to 9 of them).
// The result of pixel p is produced by the word p+width+1 of the frame and
// passes through the column queue and the s1, s2, s3 and output registers.
// One word per clock is accepted while in_ch.ready is high: each line
// store does one read and one write per cycle, with a bypass for
// back-to-back use of one entry. Drains inside a frame and pixels
// between frame end and the last drain are accepted and dropped.
// Reset clears all position counters, sets width 1024 and height 1; line
// store contents are undefined and only ever land on masked neighbors.
// When out_ch stalls, a 4-deep column queue fills and then in_ch.ready drops.
// Width (byte address 0) and height (byte address 4) are to be written over
// APB between frames; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream #(
	parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bbs_in_if.sink                       in_ch,
	bbs_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbs_pkg::APB_AW-1:0]   paddr,
	input  logic [bbs_pkg::APB_DW-1:0]   pwdata,
	output logic [bbs_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	logic [bbs_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [bbs_pkg::HEIGHT_REG_W-1:0] height_q;
	bbs_pkg::reg_idx_t                reg_idx;

	logic                       push;
	bbs_pkg::col_item_t         push_item;
	logic                       pop;
	logic                       head_valid;
	bbs_pkg::col_item_t         head_item;
	logic [bbs_pkg::QLVL_W-1:0] q_level;
	logic                       front_ready;

	assign pready  = 1'b1;
	assign reg_idx = bbs_pkg::reg_idx_t'(paddr[2]);

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbs_pkg::WIDTH_RESET;
			height_q <= bbs_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				bbs_pkg::REG_WIDTH:  width_q  <= pwdata[bbs_pkg::WIDTH_REG_W-1:0];
				bbs_pkg::REG_HEIGHT: height_q <= pwdata[bbs_pkg::HEIGHT_REG_W-1:0];
				default:             width_q  <= width_q;
			endcase
		end
	end

	// Register read back; unaligned addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (reg_idx)
				bbs_pkg::REG_WIDTH:  prdata = bbs_pkg::APB_DW'(width_q);
				bbs_pkg::REG_HEIGHT: prdata = bbs_pkg::APB_DW'(height_q);
				default:             prdata = '0;
			endcase
		end
	end

	bbs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.in_valid   (in_ch.valid),
		.in_ready   (front_ready),
		.opcode     (in_ch.opcode),
		.in_pixel   ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
		.q_level    (q_level),
		.push       (push),
		.push_item  (push_item)
	);

	assign in_ch.ready = front_ready;

	bbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.level      (q_level)
	);

	bbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (head_valid),
		.q_item     (head_item),
		.q_pop      (pop),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.red_out    (out_ch.red_out),
		.green_out  (out_ch.green_out),
		.blue_out   (out_ch.blue_out),
		.frame_done (out_ch.frame_done)
	);

endmodule
